>>> src/particle_integrator_2d_top_macros.svh
// Assertion helpers for the integrator; define NO_ASSERTIONS to drop them.
`ifndef PARTICLE_INTEGRATOR_2D_TOP_MACROS_SVH
`define PARTICLE_INTEGRATOR_2D_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define PIT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("particle_integrator_2d: check failed");

// Checked on every clock edge, reset included.
`define PIT_ASSERT_RESET(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("particle_integrator_2d: reset check failed");

`else

`define PIT_ASSERT(lbl, prop)
`define PIT_ASSERT_RESET(lbl, prop)

`endif

`endif

>>> src/pi2d_pkg.sv
package pi2d_pkg;

   localparam int DVD_W     = 48;
   localparam int DIV_STEPS = DVD_W;
   localparam int REM_W     = 32;
   localparam int SAT_W     = 66;

   localparam logic [2:0] OP_HALF_DRIFT = 3'd0;
   localparam logic [2:0] OP_KICK_DRIFT = 3'd1;
   localparam logic [2:0] OP_RK4        = 3'd2;
   localparam logic [2:0] OP_FORCE      = 3'd3;
   localparam logic [2:0] OP_DAMP       = 3'd4;

   localparam logic [1:0] CSR_TIME_STEP = 2'd0;
   localparam logic [1:0] CSR_DAMPING   = 2'd1;

   localparam logic [30:0] TIME_STEP_RESET = 31'd655;
   localparam logic [16:0] DAMPING_RESET   = 17'd65536;

   localparam logic signed [SAT_W-1:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [SAT_W-1:0] SAT_MIN = -66'sd2147483648;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic [30:0]        body_mass;
   } pi2d_req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic               saturated;
   } pi2d_rsp_type;

   typedef struct packed {
      logic               flag;
      logic signed [31:0] value;
   } pi2d_sat_type;

   // Clamp to signed 32 bits, flagging a clamp.
   function automatic pi2d_sat_type sat32(input logic signed [SAT_W-1:0] v);
      pi2d_sat_type r;
      if (v > SAT_MAX) begin
         r.flag  = 1'b1;
         r.value = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r.flag  = 1'b1;
         r.value = 32'sh8000_0000;
      end else begin
         r.flag  = 1'b0;
         r.value = $signed(v[31:0]);
      end
      return r;
   endfunction

endpackage

>>> src/pi2d_div.sv
module pi2d_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  pi2d_pkg::pi2d_req_type     in_item,
   input  logic [pi2d_pkg::DVD_W-1:0] in_dvd_x,
   input  logic [pi2d_pkg::DVD_W-1:0] in_dvd_y,
   output logic                       out_valid,
   output pi2d_pkg::pi2d_req_type     out_item,
   output logic [pi2d_pkg::DVD_W-1:0] out_quo_x,
   output logic [pi2d_pkg::DVD_W-1:0] out_quo_y
);
   import pi2d_pkg::*;

   // One restoring step per stage; the dividend shifts out as quotient bits shift in.
   logic               valid_ff [DIV_STEPS];
   pi2d_req_type       item_ff  [DIV_STEPS];
   logic [DVD_W-1:0]   dvd_x_ff [DIV_STEPS];
   logic [DVD_W-1:0]   dvd_y_ff [DIV_STEPS];
   logic [REM_W-1:0]   rem_x_ff [DIV_STEPS];
   logic [REM_W-1:0]   rem_y_ff [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic             v_prev;
      pi2d_req_type     it_prev;
      logic [DVD_W-1:0] dx_prev;
      logic [DVD_W-1:0] dy_prev;
      logic [REM_W-1:0] rx_prev;
      logic [REM_W-1:0] ry_prev;
      logic [REM_W-1:0] rx_sh;
      logic [REM_W-1:0] ry_sh;
      logic [REM_W-1:0] dvs;
      logic             gx;
      logic             gy;

      if (k == 0) begin : g_first
         assign v_prev  = in_valid;
         assign it_prev = in_item;
         assign dx_prev = in_dvd_x;
         assign dy_prev = in_dvd_y;
         assign rx_prev = '0;
         assign ry_prev = '0;
      end else begin : g_next
         assign v_prev  = valid_ff[k-1];
         assign it_prev = item_ff[k-1];
         assign dx_prev = dvd_x_ff[k-1];
         assign dy_prev = dvd_y_ff[k-1];
         assign rx_prev = rem_x_ff[k-1];
         assign ry_prev = rem_y_ff[k-1];
      end

      assign dvs   = {1'b0, it_prev.body_mass};
      assign rx_sh = {rx_prev[REM_W-2:0], dx_prev[DVD_W-1]};
      assign ry_sh = {ry_prev[REM_W-2:0], dy_prev[DVD_W-1]};
      assign gx    = (rx_sh >= dvs);
      assign gy    = (ry_sh >= dvs);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            item_ff[k]  <= it_prev;
            rem_x_ff[k] <= gx ? (rx_sh - dvs) : rx_sh;
            rem_y_ff[k] <= gy ? (ry_sh - dvs) : ry_sh;
            dvd_x_ff[k] <= {dx_prev[DVD_W-2:0], gx};
            dvd_y_ff[k] <= {dy_prev[DVD_W-2:0], gy};
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_item  = item_ff[DIV_STEPS-1];
   assign out_quo_x = dvd_x_ff[DIV_STEPS-1];
   assign out_quo_y = dvd_y_ff[DIV_STEPS-1];

endmodule

>>> src/particle_integrator_2d_top.sv
// Leapfrog/RK4 integrator for one 2D body per transaction, signed Q16.16.
// A new transaction is taken every cycle unless the output holds; each result
// passes through one input stage, 48 divider stages, four arithmetic stages
// and the output register. The depth is set by the one-bit-per-stage
// divider that apply force needs; every operation runs through it so results
// leave in order. When a result waits at the output, the whole pipeline holds.
module particle_integrator_2d_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pi2d_pkg::pi2d_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pi2d_pkg::pi2d_rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [30:0]            csr_wdata
);
   import pi2d_pkg::*;

   logic [30:0] time_step_ff;
   logic [16:0] damping_ff;
   logic signed [31:0] dts;
   logic signed [17:0] damps;
   logic adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         damping_ff   <= DAMPING_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIME_STEP: time_step_ff <= csr_wdata;
            CSR_DAMPING:   damping_ff   <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   assign dts   = $signed({1'b0, time_step_ff});
   assign damps = $signed({1'b0, damping_ff});

   logic         rsp_valid_ff;
   pi2d_rsp_type rsp_data_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Input stage
   logic         v0_ff;
   pi2d_req_type it0_ff;
   logic [31:0]  mag_x;
   logic [31:0]  mag_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it0_ff <= req_data;
      end
   end

   assign mag_x = it0_ff.accel_x[31] ? (~it0_ff.accel_x + 32'd1) : it0_ff.accel_x;
   assign mag_y = it0_ff.accel_y[31] ? (~it0_ff.accel_y + 32'd1) : it0_ff.accel_y;

   // Divider: |F| * 2^16 / mass for both axes
   logic             dv_valid;
   pi2d_req_type     dv_item;
   logic [DVD_W-1:0] quo_x;
   logic [DVD_W-1:0] quo_y;

   pi2d_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v0_ff),
      .in_item   (it0_ff),
      .in_dvd_x  ({mag_x, 16'd0}),
      .in_dvd_y  ({mag_y, 16'd0}),
      .out_valid (dv_valid),
      .out_item  (dv_item),
      .out_quo_x (quo_x),
      .out_quo_y (quo_y)
   );

   // Stage A: first products, signed quotient
   logic               va_ff;
   pi2d_req_type       it_a_ff;
   logic signed [63:0] pa_x_ff, pa_y_ff, pv_x_ff, pv_y_ff;
   logic signed [49:0] pd_x_ff, pd_y_ff;
   logic signed [48:0] qs_x_ff, qs_y_ff;
   logic signed [63:0] pa_x_in, pa_y_in, pv_x_in, pv_y_in;
   logic signed [49:0] pd_x_in, pd_y_in;
   logic signed [48:0] qs_x_in, qs_y_in;

   assign pa_x_in = dv_item.accel_x * dts;
   assign pa_y_in = dv_item.accel_y * dts;
   assign pv_x_in = dv_item.vel_x * dts;
   assign pv_y_in = dv_item.vel_y * dts;
   assign pd_x_in = dv_item.vel_x * damps;
   assign pd_y_in = dv_item.vel_y * damps;
   assign qs_x_in = dv_item.accel_x[31] ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
   assign qs_y_in = dv_item.accel_y[31] ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it_a_ff <= dv_item;
         pa_x_ff <= pa_x_in;
         pa_y_ff <= pa_y_in;
         pv_x_ff <= pv_x_in;
         pv_y_ff <= pv_y_in;
         pd_x_ff <= pd_x_in;
         pd_y_ff <= pd_y_in;
         qs_x_ff <= qs_x_in;
         qs_y_ff <= qs_y_in;
      end
   end

   // Stage B: new velocity
   logic               vb_ff;
   pi2d_req_type       it_b_ff;
   logic signed [31:0] vel_x_b_ff, vel_y_b_ff;
   logic               flag_b_ff;
   logic signed [63:0] pv_x_b_ff, pv_y_b_ff;
   logic signed [47:0] d_x_b_ff, d_y_b_ff;
   logic signed [47:0] d_x, d_y;
   pi2d_sat_type       kick_x, kick_y, frc_x, frc_y, dmp_x, dmp_y;
   logic signed [31:0] vel_x_b_in, vel_y_b_in;
   logic               flag_b_in;

   assign d_x    = $signed(pa_x_ff[63:16]);
   assign d_y    = $signed(pa_y_ff[63:16]);
   assign kick_x = sat32(SAT_W'(it_a_ff.vel_x) + SAT_W'(d_x));
   assign kick_y = sat32(SAT_W'(it_a_ff.vel_y) + SAT_W'(d_y));
   assign frc_x  = sat32(SAT_W'(it_a_ff.vel_x) + SAT_W'(qs_x_ff));
   assign frc_y  = sat32(SAT_W'(it_a_ff.vel_y) + SAT_W'(qs_y_ff));
   assign dmp_x  = sat32(SAT_W'($signed(pd_x_ff[49:16])));
   assign dmp_y  = sat32(SAT_W'($signed(pd_y_ff[49:16])));

   always_comb begin
      vel_x_b_in = it_a_ff.vel_x;
      vel_y_b_in = it_a_ff.vel_y;
      flag_b_in  = 1'b0;
      unique case (it_a_ff.operation)
         OP_KICK_DRIFT, OP_RK4: begin
            vel_x_b_in = kick_x.value;
            vel_y_b_in = kick_y.value;
            flag_b_in  = kick_x.flag | kick_y.flag;
         end
         OP_FORCE: begin
            if (it_a_ff.body_mass == 31'd0) begin
               flag_b_in = 1'b1;
            end else begin
               vel_x_b_in = frc_x.value;
               vel_y_b_in = frc_y.value;
               flag_b_in  = frc_x.flag | frc_y.flag;
            end
         end
         OP_DAMP: begin
            vel_x_b_in = dmp_x.value;
            vel_y_b_in = dmp_y.value;
            flag_b_in  = dmp_x.flag | dmp_y.flag;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it_b_ff    <= it_a_ff;
         vel_x_b_ff <= vel_x_b_in;
         vel_y_b_ff <= vel_y_b_in;
         flag_b_ff  <= flag_b_in;
         pv_x_b_ff  <= pv_x_ff;
         pv_y_b_ff  <= pv_y_ff;
         d_x_b_ff   <= d_x;
         d_y_b_ff   <= d_y;
      end
   end

   // Stage C: second products (new velocity, split velocity increment)
   logic               vc_ff;
   pi2d_req_type       it_c_ff;
   logic signed [31:0] vel_x_c_ff, vel_y_c_ff;
   logic               flag_c_ff;
   logic signed [63:0] pv_x_c_ff, pv_y_c_ff;
   logic signed [63:0] pk_x_ff, pk_y_ff, ph_x_ff, ph_y_ff, pl_x_ff, pl_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it_c_ff    <= it_b_ff;
         vel_x_c_ff <= vel_x_b_ff;
         vel_y_c_ff <= vel_y_b_ff;
         flag_c_ff  <= flag_b_ff;
         pv_x_c_ff  <= pv_x_b_ff;
         pv_y_c_ff  <= pv_y_b_ff;
         pk_x_ff    <= vel_x_b_ff * dts;
         pk_y_ff    <= vel_y_b_ff * dts;
         ph_x_ff    <= $signed(d_x_b_ff[47:16]) * dts;
         ph_y_ff    <= $signed(d_y_b_ff[47:16]) * dts;
         pl_x_ff    <= $signed({1'b0, d_x_b_ff[15:0]}) * dts;
         pl_y_ff    <= $signed({1'b0, d_y_b_ff[15:0]}) * dts;
      end
   end

   // Stage D: position increment
   logic               vd_ff;
   pi2d_req_type       it_d_ff;
   logic signed [31:0] vel_x_d_ff, vel_y_d_ff;
   logic               flag_d_ff;
   logic signed [SAT_W-1:0] t_x_d_ff, t_y_d_ff;
   logic signed [SAT_W-1:0] t_x_in, t_y_in;
   logic [64:0] low_x, low_y;

   // Low half of d*dt/2: odd bit of the high product joins the low product.
   assign low_x = 65'(pl_x_ff) + 65'({ph_x_ff[0], 16'd0});
   assign low_y = 65'(pl_y_ff) + 65'({ph_y_ff[0], 16'd0});

   always_comb begin
      t_x_in = '0;
      t_y_in = '0;
      unique case (it_c_ff.operation)
         OP_HALF_DRIFT: begin
            t_x_in = SAT_W'($signed(pv_x_c_ff[63:17]));
            t_y_in = SAT_W'($signed(pv_y_c_ff[63:17]));
         end
         OP_KICK_DRIFT: begin
            t_x_in = SAT_W'($signed(pk_x_ff[63:17]));
            t_y_in = SAT_W'($signed(pk_y_ff[63:17]));
         end
         OP_RK4: begin
            t_x_in = SAT_W'($signed(pv_x_c_ff[63:16])) + SAT_W'($signed(ph_x_ff[63:1]))
                   + $signed(SAT_W'(low_x[64:17]));
            t_y_in = SAT_W'($signed(pv_y_c_ff[63:16])) + SAT_W'($signed(ph_y_ff[63:1]))
                   + $signed(SAT_W'(low_y[64:17]));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (adv) begin
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it_d_ff    <= it_c_ff;
         vel_x_d_ff <= vel_x_c_ff;
         vel_y_d_ff <= vel_y_c_ff;
         flag_d_ff  <= flag_c_ff;
         t_x_d_ff   <= t_x_in;
         t_y_d_ff   <= t_y_in;
      end
   end

   // Output stage: new position
   pi2d_sat_type pos_x_sat, pos_y_sat;
   pi2d_rsp_type rsp_data_in;
   logic         moves;

   assign pos_x_sat = sat32(SAT_W'(it_d_ff.pos_x) + t_x_d_ff);
   assign pos_y_sat = sat32(SAT_W'(it_d_ff.pos_y) + t_y_d_ff);
   assign moves = (it_d_ff.operation == OP_HALF_DRIFT) || (it_d_ff.operation == OP_KICK_DRIFT)
               || (it_d_ff.operation == OP_RK4);

   always_comb begin
      rsp_data_in.new_vel_x = vel_x_d_ff;
      rsp_data_in.new_vel_y = vel_y_d_ff;
      if (moves) begin
         rsp_data_in.new_pos_x = pos_x_sat.value;
         rsp_data_in.new_pos_y = pos_y_sat.value;
         rsp_data_in.saturated = flag_d_ff | pos_x_sat.flag | pos_y_sat.flag;
      end else begin
         rsp_data_in.new_pos_x = it_d_ff.pos_x;
         rsp_data_in.new_pos_y = it_d_ff.pos_y;
         rsp_data_in.saturated = flag_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`include "particle_integrator_2d_top_macros.svh"

   `PIT_ASSERT(a_zero_mass_flag, vb_ff && it_b_ff.operation == OP_FORCE && it_b_ff.body_mass == 31'd0 |-> flag_b_ff && vel_x_b_ff == it_b_ff.vel_x)
   `PIT_ASSERT(a_unused_op_pass, vc_ff && it_c_ff.operation > OP_DAMP |-> !flag_c_ff && vel_y_c_ff == it_c_ff.vel_y)
   `PIT_ASSERT(a_drift_keeps_vel, vd_ff && it_d_ff.operation == OP_HALF_DRIFT |-> vel_x_d_ff == it_d_ff.vel_x && !flag_d_ff)
   `PIT_ASSERT_RESET(a_reset_empty, reset |=> !rsp_valid_ff && !vd_ff && !v0_ff)

endmodule

>>> tb/testbench.sv
module testbench;
   import pi2d_pkg::*;

   localparam int LATENCY     = 54;
   localparam int WATCHDOG_MAX = 20000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   pi2d_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   pi2d_rsp_type rsp_data;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [30:0]  csr_wdata;

   logic [30:0]  step_dt;
   logic [16:0]  damp_scale;

   pi2d_rsp_type pending_bodies[$];
   int           mismatch_count;
   int           bodies_sent;
   int           bodies_checked;
   int           idle_cycles;
   int           rsp_hold;
   bit           long_stalls;

   particle_integrator_2d_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [65:0] floor_div(input logic signed [65:0] v, input int s);
      return v >>> s;
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [65:0] v,
                                                  inout logic flag);
      if (v > 66'sd2147483647) begin
         flag = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -66'sd2147483648) begin
         flag = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic pi2d_rsp_type integrate_body(input pi2d_req_type b);
      pi2d_rsp_type r;
      logic signed [65:0] dt, dmp, m, dx, dy, qx, qy;
      logic signed [95:0] hx, hy;
      logic f;
      dt  = $signed({35'd0, step_dt});
      dmp = $signed({49'd0, damp_scale});
      m   = $signed({35'd0, b.body_mass});
      f = 1'b0;
      r.new_pos_x = b.pos_x;
      r.new_pos_y = b.pos_y;
      r.new_vel_x = b.vel_x;
      r.new_vel_y = b.vel_y;
      case (b.operation)
         OP_HALF_DRIFT: begin
            r.new_pos_x = clamp32(b.pos_x + floor_div(b.vel_x * dt, 17), f);
            r.new_pos_y = clamp32(b.pos_y + floor_div(b.vel_y * dt, 17), f);
         end
         OP_KICK_DRIFT: begin
            r.new_vel_x = clamp32(b.vel_x + floor_div(b.accel_x * dt, 16), f);
            r.new_vel_y = clamp32(b.vel_y + floor_div(b.accel_y * dt, 16), f);
            r.new_pos_x = clamp32(b.pos_x + floor_div(r.new_vel_x * dt, 17), f);
            r.new_pos_y = clamp32(b.pos_y + floor_div(r.new_vel_y * dt, 17), f);
         end
         OP_RK4: begin
            dx = floor_div(b.accel_x * dt, 16);
            dy = floor_div(b.accel_y * dt, 16);
            r.new_vel_x = clamp32(b.vel_x + dx, f);
            r.new_vel_y = clamp32(b.vel_y + dy, f);
            // d*dt approaches 2^77, so form it wider and shift before narrowing
            hx = dx * dt;
            hy = dy * dt;
            r.new_pos_x = clamp32(b.pos_x + floor_div(b.vel_x * dt, 16)
                                  + 66'(hx >>> 17), f);
            r.new_pos_y = clamp32(b.pos_y + floor_div(b.vel_y * dt, 16)
                                  + 66'(hy >>> 17), f);
         end
         OP_FORCE: begin
            if (b.body_mass == '0) begin
               f = 1'b1;
            end else begin
               qx = (b.accel_x * 66'sd65536) / m;
               qy = (b.accel_y * 66'sd65536) / m;
               r.new_vel_x = clamp32(b.vel_x + qx, f);
               r.new_vel_y = clamp32(b.vel_y + qy, f);
            end
         end
         OP_DAMP: begin
            r.new_vel_x = clamp32(floor_div(b.vel_x * dmp, 16), f);
            r.new_vel_y = clamp32(floor_div(b.vel_y * dmp, 16), f);
         end
         default: ;
      endcase
      r.saturated = f;
      return r;
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on body %0d, %s: got %h expected %h",
               bodies_checked, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_body(input pi2d_req_type b);
      int gap;
      gap = long_stalls ? random_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (!req_ready);
      pending_bodies.push_back(integrate_body(b));
      bodies_sent++;
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [30:0] val);
      // drain first: registers change only while the pipeline is empty
      req_valid <= 1'b0;
      while (pending_bodies.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TIME_STEP) step_dt = val;
      else if (idx == CSR_DAMPING) damp_scale = val[16:0];
   endtask

   function automatic logic [31:0] rand32();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0010_0000)
                                        : -$urandom_range(0, 32'h0010_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic pi2d_req_type random_body(input int max_op);
      pi2d_req_type b;
      b.operation = 3'($urandom_range(0, max_op));
      b.pos_x   = rand32();
      b.pos_y   = rand32();
      b.vel_x   = rand32();
      b.vel_y   = rand32();
      b.accel_x = rand32();
      b.accel_y = rand32();
      case ($urandom_range(0, 5))
         0: b.body_mass = '0;
         1: b.body_mass = 31'h7FFF_FFFF;
         2: b.body_mass = 31'($urandom_range(1, 3));
         default: b.body_mass = 31'($urandom);
      endcase
      return b;
   endfunction

   // response side: random backpressure when long_stalls is set, compare against oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_bodies.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.new_pos_x, '0);
            end else begin
               pi2d_rsp_type want;
               want = pending_bodies.pop_front();
               if (rsp_data.new_pos_x !== want.new_pos_x)
                  report_mismatch("new_pos_x", rsp_data.new_pos_x, want.new_pos_x);
               if (rsp_data.new_pos_y !== want.new_pos_y)
                  report_mismatch("new_pos_y", rsp_data.new_pos_y, want.new_pos_y);
               if (rsp_data.new_vel_x !== want.new_vel_x)
                  report_mismatch("new_vel_x", rsp_data.new_vel_x, want.new_vel_x);
               if (rsp_data.new_vel_y !== want.new_vel_y)
                  report_mismatch("new_vel_y", rsp_data.new_vel_y, want.new_vel_y);
               if (rsp_data.saturated !== want.saturated)
                  report_mismatch("saturated", 32'(rsp_data.saturated),
                                  32'(want.saturated));
               bodies_checked++;
            end
         end
         if (!long_stalls) begin
            rsp_ready <= 1'b1;
         end else if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= rsp_hold - 1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= random_gap();
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: count cycles with no handshake on either channel while work is outstanding
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (req_valid || pending_bodies.size() != 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("watchdog expired");
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   task automatic test_directed_extremes();
      pi2d_req_type b;
      logic [31:0] ext[4];
      ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
      for (int op = 0; op < 8; op++) begin
         for (int k = 0; k < 2; k++) begin
            b.operation = 3'(op);
            b.pos_x = ext[k]; b.pos_y = ext[k + 2];
            b.vel_x = ext[k]; b.vel_y = ext[3 - k];
            b.accel_x = ext[k]; b.accel_y = ext[1 - k];
            b.body_mass = k ? 31'h7FFF_FFFF : 31'd1;
            send_body(b);
         end
      end
      // zero mass on apply force
      b.operation = OP_FORCE; b.body_mass = '0;
      send_body(b);
      b.body_mass = 31'd65536; b.accel_x = 32'sd65536; b.accel_y = -32'sd65536;
      b.vel_x = 32'sd100; b.vel_y = 32'sd100;
      send_body(b);
   endtask

   task automatic test_random_phase(input int count, input int max_op);
      for (int i = 0; i < count; i++) send_body(random_body(max_op));
   endtask

   task automatic test_register_settings();
      write_register(CSR_TIME_STEP, 31'h7FFF_FFFF);
      test_random_phase(60, 7);
      write_register(CSR_TIME_STEP, 31'd0);
      write_register(CSR_DAMPING, 31'd0);
      test_random_phase(60, 7);
      // damping above one saturates
      write_register(CSR_DAMPING, 31'h1FFFF);
      write_register(CSR_TIME_STEP, 31'd65536);
      test_random_phase(60, 7);
      write_register(CSR_DAMPING, 31'd65536);
      write_register(CSR_TIME_STEP, 31'($urandom));
      test_random_phase(80, 4);
      // unknown index must be ignored
      write_register(2'd3, 31'd12345);
      write_register(2'd2, 31'd12345);
      write_register(CSR_DAMPING, 31'($urandom_range(0, 65536)));
      write_register(CSR_TIME_STEP, 31'($urandom_range(1, 32'h0002_0000)));
      test_random_phase(120, 4);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      bodies_sent = 0;
      bodies_checked = 0;
      long_stalls = 1'b0;
      step_dt = TIME_STEP_RESET;
      damp_scale = DAMPING_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_random_phase(60, 4);
      long_stalls = 1'b1;
      test_random_phase(200, 7);
      test_register_settings();

      req_valid <= 1'b0;
      while (pending_bodies.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d bodies over all operations, unused codes and several",
               bodies_sent);
      $display("time step and damping settings; %0d results compared", bodies_checked);
      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/pi2d_pkg.sv
src/pi2d_div.sv
src/particle_integrator_2d_top.sv
tb/testbench.sv
